// File: src/clock_buffer_frame_manager_macros.svh
// Assertion helpers used by the frame manager controller.
`ifndef CLOCK_BUFFER_FRAME_MANAGER_MACROS_SVH
`define CLOCK_BUFFER_FRAME_MANAGER_MACROS_SVH
`define CBFM_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define CBFM_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// File: src/cbfm_pkg.sv
package cbfm_pkg;
  localparam int NUM_FRAMES = 16;
  localparam int PIN_COUNT_BITS = 8;
  localparam int FRAME_BITS = $clog2(NUM_FRAMES);
  localparam int SEEN_BITS = $clog2(NUM_FRAMES + 1);
  localparam logic [PIN_COUNT_BITS-1:0] PIN_MAX = '1;

  localparam logic [2:0] MODE_READ    = 3'd0;
  localparam logic [2:0] MODE_UNPIN   = 3'd1;
  localparam logic [2:0] MODE_ALLOC   = 3'd2;
  localparam logic [2:0] MODE_DISPOSE = 3'd3;
  localparam logic [2:0] MODE_FLUSH   = 3'd4;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_EXCEEDED   = 2'd1;
  localparam logic [1:0] ST_NOT_PINNED = 2'd2;
  localparam logic [1:0] ST_PINNED     = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] file_id;
    logic [31:0] page_no;
    logic        dirty;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  frame;
    logic        hit;
    logic        fetch_page;
    logic        write_back;
    logic [15:0] wb_file_id;
    logic [31:0] wb_page_no;
    logic        delete_page;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOOKUP, S_DECIDE, S_SWEEP, S_FLUSH, S_EMIT
  } state_t;

  // Operations the controller asks of the datapath.
  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_LOOKUP, OP_HIT_READ, OP_UNPIN, OP_DISPOSE,
    OP_MISS_RESP, OP_SWEEP_START, OP_SWEEP_STEP, OP_FLUSH_START, OP_FLUSH_STEP,
    OP_TAKE
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       found;
    logic       sweep_done;
    logic       flush_done;
    logic       flush_emit;
    logic       out_full;
  } stat_t;
endpackage

// File: src/cbfm_datapath.sv
module cbfm_datapath import cbfm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      cmd,
  input  in_item_t  in_data,
  output stat_t     stat,
  output out_item_t out_data,
  input  logic      out_pop
);
  logic [NUM_FRAMES-1:0] fv, fr, fd;
  logic [PIN_COUNT_BITS-1:0] fp [NUM_FRAMES];
  logic [15:0] ft [NUM_FRAMES];
  logic [31:0] pt [NUM_FRAMES];
  logic [FRAME_BITS-1:0] hand;
  in_item_t req;
  logic [NUM_FRAMES-1:0] match;
  logic found;
  logic [FRAME_BITS-1:0] fidx;
  logic [NUM_FRAMES-1:0] seen;
  logic [SEEN_BITS-1:0] nseen;
  logic sweep_done, flush_done, flush_emit;
  logic [FRAME_BITS-1:0] walk;
  logic walk_end;
  logic out_full;
  out_item_t outr;

  logic [FRAME_BITS-1:0] hn;
  logic [FRAME_BITS-1:0] enc;
  logic any;

  assign hn = (hand == FRAME_BITS'(NUM_FRAMES - 1)) ? '0 : hand + 1'b1;

  always_comb begin
    any = 1'b0;
    enc = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if (match[i]) begin
        any = 1'b1;
        enc = FRAME_BITS'(i);
      end
    end
  end

  function automatic out_item_t mk(logic [1:0] s, logic [FRAME_BITS-1:0] f, logic h,
                                   logic fe, logic w, logic [15:0] wf,
                                   logic [31:0] wp, logic del, logic l);
    out_item_t o;
    o.status = s;
    o.frame = 4'(f);
    o.hit = h;
    o.fetch_page = fe;
    o.write_back = w;
    o.wb_file_id = wf;
    o.wb_page_no = wp;
    o.delete_page = del;
    o.last = l;
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
      fr <= '0;
      fd <= '0;
      hand <= FRAME_BITS'(NUM_FRAMES - 1);
      out_full <= 1'b0;
      sweep_done <= 1'b0;
      flush_done <= 1'b0;
      flush_emit <= 1'b0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        fp[i] <= '0;
        ft[i] <= '0;
        pt[i] <= '0;
      end
    end else begin
      if (out_pop) out_full <= 1'b0;
      unique case (cmd.op)
        OP_NONE: ;
        OP_LATCH: req <= in_data;
        OP_LOOKUP: begin
          for (int i = 0; i < NUM_FRAMES; i++)
            match[i] <= fv[i] && ft[i] == req.file_id && pt[i] == req.page_no;
        end
        OP_TAKE: begin
          found <= any;
          fidx <= enc;
        end
        OP_HIT_READ: begin
          fr[fidx] <= 1'b1;
          if (fp[fidx] != PIN_MAX) fp[fidx] <= fp[fidx] + 1'b1;
          outr <= mk(ST_OK, fidx, 1'b1, 1'b0, 1'b0, '0, '0, 1'b0, 1'b1);
          out_full <= 1'b1;
        end
        OP_UNPIN: begin
          if (!found) begin
            outr <= mk(ST_OK, '0, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b1);
          end else if (fp[fidx] == '0) begin
            outr <= mk(ST_NOT_PINNED, fidx, 1'b1, 1'b0, 1'b0, '0, '0, 1'b0, 1'b1);
          end else begin
            if (req.dirty) fd[fidx] <= 1'b1;
            fp[fidx] <= fp[fidx] - 1'b1;
            outr <= mk(ST_OK, fidx, 1'b1, 1'b0, 1'b0, '0, '0, 1'b0, 1'b1);
          end
          out_full <= 1'b1;
        end
        OP_DISPOSE: begin
          if (found) begin
            fv[fidx] <= 1'b0;
            fr[fidx] <= 1'b0;
            fd[fidx] <= 1'b0;
            fp[fidx] <= '0;
            ft[fidx] <= '0;
            pt[fidx] <= '0;
            outr <= mk(ST_OK, fidx, 1'b1, 1'b0, 1'b0, '0, '0, 1'b1, 1'b1);
          end else begin
            outr <= mk(ST_OK, '0, 1'b0, 1'b0, 1'b0, '0, '0, 1'b1, 1'b1);
          end
          out_full <= 1'b1;
        end
        OP_MISS_RESP: begin
          // Unused modes answer with an empty final transaction.
          outr <= mk(ST_OK, '0, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b1);
          out_full <= 1'b1;
        end
        OP_SWEEP_START: begin
          seen <= '0;
          nseen <= '0;
          sweep_done <= 1'b0;
        end
        OP_SWEEP_STEP: begin
          hand <= hn;
          if (nseen >= SEEN_BITS'(NUM_FRAMES)) begin
            outr <= mk(ST_EXCEEDED, '0, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b1);
            out_full <= 1'b1;
            sweep_done <= 1'b1;
          end else if (fr[hn] && fv[hn]) begin
            fr[hn] <= 1'b0;
          end else if (fv[hn] && fp[hn] != '0) begin
            if (!seen[hn]) begin
              seen[hn] <= 1'b1;
              nseen <= nseen + 1'b1;
            end
          end else begin
            // Free or evictable frame: install the requested page here.
            outr <= mk(ST_OK, hn, 1'b0, req.mode == MODE_READ, fv[hn] && fd[hn],
                       (fv[hn] && fd[hn]) ? ft[hn] : 16'd0,
                       (fv[hn] && fd[hn]) ? pt[hn] : 32'd0, 1'b0, 1'b1);
            out_full <= 1'b1;
            sweep_done <= 1'b1;
            fv[hn] <= 1'b1;
            fr[hn] <= 1'b1;
            fp[hn] <= PIN_COUNT_BITS'(1);
            fd[hn] <= 1'b0;
            ft[hn] <= req.file_id;
            pt[hn] <= req.page_no;
          end
        end
        OP_FLUSH_START: begin
          walk <= '0;
          walk_end <= 1'b0;
          flush_done <= 1'b0;
          flush_emit <= 1'b0;
        end
        OP_FLUSH_STEP: begin
          if (walk_end) begin
            outr <= mk(ST_OK, '0, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b1);
            out_full <= 1'b1;
            flush_done <= 1'b1;
            flush_emit <= 1'b0;
          end else begin
            if (walk == FRAME_BITS'(NUM_FRAMES - 1)) walk_end <= 1'b1;
            else walk <= walk + 1'b1;
            flush_emit <= fv[walk] && ft[walk] == req.file_id && fp[walk] == '0 &&
                          fd[walk];
            if (fv[walk] && ft[walk] == req.file_id) begin
              if (fp[walk] != '0) begin
                outr <= mk(ST_PINNED, walk, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b1);
                out_full <= 1'b1;
                flush_done <= 1'b1;
              end else begin
                if (fd[walk]) begin
                  outr <= mk(ST_OK, walk, 1'b0, 1'b0, 1'b1, ft[walk], pt[walk],
                             1'b0, 1'b0);
                  out_full <= 1'b1;
                end
                fv[walk] <= 1'b0;
                fr[walk] <= 1'b0;
                fd[walk] <= 1'b0;
                fp[walk] <= '0;
                ft[walk] <= '0;
                pt[walk] <= '0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign stat.mode = req.mode;
  assign stat.found = found;
  assign stat.sweep_done = sweep_done;
  assign stat.flush_done = flush_done;
  assign stat.flush_emit = flush_emit;
  assign stat.out_full = out_full;
  assign out_data = outr;
endmodule

// File: src/cbfm_ctrl.sv
module cbfm_ctrl import cbfm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_fire,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  in_ready,
  output logic  out_valid
);
`include "clock_buffer_frame_manager_macros.svh"
  state_t state, state_next;
  logic step_ok;

  assign step_ok = !stat.out_full;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_fire) state_next = S_LOOKUP;
      S_LOOKUP: state_next = S_DECIDE;
      S_DECIDE: state_next = S_EMIT;
      S_EMIT: begin
        priority if (stat.mode == MODE_READ && !stat.found) state_next = S_SWEEP;
        else if (stat.mode == MODE_ALLOC) state_next = S_SWEEP;
        else if (stat.mode == MODE_FLUSH) state_next = S_FLUSH;
        else state_next = S_IDLE;
      end
      S_SWEEP: if (stat.sweep_done) state_next = S_IDLE;
      S_FLUSH: if (stat.flush_done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_NONE;
    unique case (state)
      S_IDLE: if (in_fire) cmd.op = OP_LATCH;
      S_LOOKUP: cmd.op = OP_LOOKUP;
      S_DECIDE: cmd.op = OP_TAKE;
      S_EMIT: begin
        priority if (stat.mode == MODE_READ && !stat.found) cmd.op = OP_SWEEP_START;
        else if (stat.mode == MODE_ALLOC) cmd.op = OP_SWEEP_START;
        else if (stat.mode == MODE_FLUSH) cmd.op = OP_FLUSH_START;
        else if (step_ok) begin
          if (stat.mode == MODE_READ) cmd.op = OP_HIT_READ;
          else if (stat.mode == MODE_UNPIN) cmd.op = OP_UNPIN;
          else if (stat.mode == MODE_DISPOSE) cmd.op = OP_DISPOSE;
          else cmd.op = OP_MISS_RESP;
        end
      end
      S_SWEEP: if (!stat.sweep_done && step_ok) cmd.op = OP_SWEEP_STEP;
      S_FLUSH: if (!stat.flush_done && step_ok) cmd.op = OP_FLUSH_STEP;
      default: cmd.op = OP_NONE;
    endcase
  end

  assign in_ready = (state == S_IDLE) && !stat.out_full;
  assign out_valid = stat.out_full;

  `CBFM_ASSERT_IMPL(a_no_accept_busy, clk, rst, in_fire, state == S_IDLE)
  `CBFM_ASSERT_NEXT(a_accept_lookup, clk, rst, in_fire, state == S_LOOKUP)
  `CBFM_ASSERT_IMPL(a_step_needs_room, clk, rst,
    cmd.op == OP_SWEEP_STEP || cmd.op == OP_FLUSH_STEP, !stat.out_full)
endmodule

// File: src/clock_buffer_frame_manager.sv
// Each operation is latched, looked up and decided, then emits its
// result; a sweep steps through frames in clock-hand order and a flush
// walks the frames, each stepping only while no result is waiting.
// One operation is in flight at a time; the input is ready again once
// the last result has been taken. Synchronous reset clears all frames
// and sets the clock hand to the last frame.
module clock_buffer_frame_manager import cbfm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  cmd_t  cmd;
  stat_t stat;

  cbfm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_valid && in_ready), .stat(stat), .cmd(cmd),
    .in_ready(in_ready), .out_valid(out_valid)
  );

  cbfm_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_data(in_data), .stat(stat),
    .out_data(out_data), .out_pop(out_valid && out_ready)
  );
endmodule
